// File: rtl/barometric_pressure_compensation_defines.svh
// Assertion macros shared by the RTL.
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_DEFINES_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define BPC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define BPC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bpc_pkg.sv
`default_nettype none
package bpc_pkg;

    localparam int CFG_W = 48;
    localparam int IDX_W = 2;

    localparam logic [IDX_W-1:0] REG_AC123 = 2'd0;
    localparam logic [IDX_W-1:0] REG_AC456 = 2'd1;
    localparam logic [IDX_W-1:0] REG_B12   = 2'd2;
    localparam logic [IDX_W-1:0] REG_MCMD  = 2'd3;

    localparam int QUEUE_DEPTH_DEF = 4;

    // Temperature front result handed to the pressure back end.
    typedef struct packed {
        logic [31:0] b5;
        logic [31:0] t;
        logic [15:0] up;
        logic        err;
    } front_word_t;

    // Unsigned restoring divide stage: one quotient bit.
    function automatic logic [64:0] div_step(input logic [31:0] rem, input logic bit_in,
                                             input logic [31:0] d);
        logic [32:0] r;
        logic [32:0] s;
        begin
            r = {rem, bit_in};
            s = r - {1'b0, d};
            if (!s[32])
                div_step = {s[31:0], 1'b1, 32'd0};
            else
                div_step = {r[31:0], 1'b0, 32'd0};
        end
    endfunction

endpackage
`default_nettype wire

// File: rtl/bpc_udiv.sv
`default_nettype none
// Pipelined unsigned 32/32 divider, one quotient bit per stage, carries a tag.
module bpc_udiv #(
    parameter int TAG_W = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_vld,
    input  wire logic [31:0]      num,
    input  wire logic [31:0]      den,
    input  wire logic [TAG_W-1:0] in_tag,
    output logic                  out_vld,
    output logic [31:0]           quot,
    output logic [TAG_W-1:0]      out_tag
);
    logic [32:0]      vld_reg;
    logic [31:0]      rem_reg [33];
    logic [31:0]      num_reg [33];
    logic [31:0]      den_reg [33];
    logic [31:0]      q_reg   [33];
    logic [TAG_W-1:0] tag_reg [33];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[31:0], in_vld};
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= '0;
        num_reg[0] <= num;
        den_reg[0] <= den;
        q_reg[0]   <= '0;
        tag_reg[0] <= in_tag;
    end

    for (genvar i = 0; i < 32; i++) begin : g_st
        logic [64:0] st;
        assign st = bpc_pkg::div_step(rem_reg[i], num_reg[i][31-i], den_reg[i]);
        always_ff @(posedge clk)
        begin
            rem_reg[i+1] <= st[64:33];
            q_reg[i+1]   <= {q_reg[i][30:0], st[32]};
            num_reg[i+1] <= num_reg[i];
            den_reg[i+1] <= den_reg[i];
            tag_reg[i+1] <= tag_reg[i];
        end
    end

    assign out_vld = vld_reg[32];
    assign quot    = q_reg[32];
    assign out_tag = tag_reg[32];
endmodule
`default_nettype wire

// File: rtl/bpc_front.sv
`default_nettype none
// Temperature path: x1, signed divide for x2, b5 and t.
module bpc_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [15:0]          raw_temperature,
    input  wire logic [15:0]          raw_pressure,
    input  wire logic [47:0]          cal_b,
    input  wire logic [31:0]          cal_m,
    output logic                      fw_vld,
    output bpc_pkg::front_word_t      fw
);
    logic [31:0] ac5, ac6, mc, md;
    assign ac5 = {16'd0, cal_b[31:16]};
    assign ac6 = {16'd0, cal_b[15:0]};
    assign mc  = {{16{cal_m[31]}}, cal_m[31:16]};
    assign md  = {{16{cal_m[15]}}, cal_m[15:0]};

    // stage 1: x1
    logic        s1_vld_reg;
    logic [31:0] s1_x1_reg, s1_a_reg;
    logic [15:0] s1_up_reg;
    logic [31:0] prod;
    assign prod = ({16'd0, raw_temperature} - ac6) * ac5;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else
            s1_vld_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        s1_x1_reg <= 32'($signed(prod) >>> 15);
        s1_a_reg  <= mc << 11;
        s1_up_reg <= raw_pressure;
    end

    // stage 2: divisor and signs
    logic [31:0] dv;
    logic        na, nd, zero;
    logic [31:0] ma, md_abs;
    assign dv     = s1_x1_reg + md;
    assign na     = s1_a_reg[31];
    assign nd     = dv[31];
    assign ma     = na ? (32'd0 - s1_a_reg) : s1_a_reg;
    assign md_abs = nd ? (32'd0 - dv) : dv;
    assign zero   = (dv == 32'd0);

    localparam int TW = 32 + 16 + 2;
    logic          d_vld;
    logic [31:0]   q;
    logic [TW-1:0] d_tag;

    bpc_udiv #(.TAG_W(TW)) u_div (
        .clk(clk), .rst_n(rst_n), .in_vld(s1_vld_reg),
        .num(ma), .den(zero ? 32'd1 : md_abs),
        .in_tag({s1_x1_reg, s1_up_reg, na ^ nd, zero}),
        .out_vld(d_vld), .quot(q), .out_tag(d_tag)
    );

    // stage after divide: b5, t = (b5+8)>>4
    logic        s3_vld_reg;
    logic [31:0] s3_b5_reg, s3_t_reg;
    logic [15:0] s3_up_reg;
    logic        s3_err_reg;
    logic [31:0] x2, b5, t16;
    assign x2  = d_tag[1] ? (32'd0 - q) : q;
    assign b5  = d_tag[TW-1 -: 32] + x2;
    assign t16 = 32'($signed(b5 + 32'd8) >>> 4);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_vld_reg <= 1'b0;
        else
            s3_vld_reg <= d_vld;
    end

    always_ff @(posedge clk)
    begin
        s3_b5_reg  <= b5;
        s3_t_reg   <= t16;
        s3_up_reg  <= d_tag[17:2];
        s3_err_reg <= d_tag[0];
    end

    // t / 10 by reciprocal: |t| < 2^28, q = (|t| * 0xCCCCCCCD) >> 35
    logic        tn;
    logic [31:0] tabs;
    logic [63:0] rp;
    assign tn   = s3_t_reg[31];
    assign tabs = tn ? (32'd0 - s3_t_reg) : s3_t_reg;
    assign rp   = {32'd0, tabs} * 64'h0000_0000_CCCC_CCCD;

    typedef struct packed {
        logic [31:0] b5;
        logic [15:0] up;
        logic        err;
    } front_hold_t;
    logic        s4_vld_reg;
    logic [28:0] s4_q_reg;
    logic        s4_n_reg;
    front_hold_t s4_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_vld_reg <= 1'b0;
        else
            s4_vld_reg <= s3_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        s4_q_reg <= rp[63:35];
        s4_n_reg <= tn;
        s4_h_reg <= '{b5: s3_b5_reg, up: s3_up_reg, err: s3_err_reg};
    end

    logic [31:0] tq;
    assign tq = {3'd0, s4_q_reg};

    assign fw_vld = s4_vld_reg;
    assign fw.b5  = s4_h_reg.b5;
    assign fw.t   = s4_n_reg ? (32'd0 - tq) : tq;
    assign fw.up  = s4_h_reg.up;
    assign fw.err = s4_h_reg.err;
endmodule
`default_nettype wire

// File: rtl/bpc_queue.sv
`default_nettype none
`include "barometric_pressure_compensation_defines.svh"
// Short FIFO between temperature front and pressure back end.
module bpc_queue #(
    parameter int DEPTH = bpc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr,
    input  wire bpc_pkg::front_word_t wdata,
    input  wire logic                 rd,
    output logic                      not_empty,
    output bpc_pkg::front_word_t      rdata
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    bpc_pkg::front_word_t mem [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (rd)
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem[wp_reg] <= wdata;
    end

    assign not_empty = (cnt_reg != '0);
    assign rdata     = mem[rp_reg];

    `BPC_ASSERT_IMP(a_no_overflow, clk, rst_n, wr && !rd, cnt_reg != (AW+1)'(DEPTH), "queue overflow")
    `BPC_ASSERT_IMP(a_no_underflow, clk, rst_n, rd, cnt_reg != '0, "queue underflow")
    `BPC_ASSERT_NXT(a_cnt_track, clk, rst_n, wr && !rd, cnt_reg == $past(cnt_reg) + 1'b1, "count slip")
endmodule
`default_nettype wire

// File: rtl/bpc_back.sv
`default_nettype none
// Pressure path: b3, b4, b7, unsigned divide, second-order correction.
module bpc_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_vld,
    input  wire bpc_pkg::front_word_t in_w,
    input  wire logic [47:0]          cal_a,
    input  wire logic [47:0]          cal_b,
    input  wire logic [31:0]          cal_c,
    output logic                      done,
    output logic [31:0]               pressure_pa,
    output logic [31:0]               temperature_c,
    output logic                      divide_error
);
    logic [31:0] ac1, ac2, ac3, ac4, b1, b2;
    assign ac1 = {{16{cal_a[47]}}, cal_a[47:32]};
    assign ac2 = {{16{cal_a[31]}}, cal_a[31:16]};
    assign ac3 = {{16{cal_a[15]}}, cal_a[15:0]};
    assign ac4 = {16'd0, cal_b[47:32]};
    assign b1  = {{16{cal_c[31]}}, cal_c[31:16]};
    assign b2  = {{16{cal_c[15]}}, cal_c[15:0]};

    typedef struct packed {
        logic [31:0] t;
        logic [15:0] up;
        logic        err;
    } ride_t;

    // p1: b6, sq product
    logic        p1_vld_reg;
    logic [31:0] p1_b6_reg, p1_sq_reg;
    ride_t       p1_r_reg;
    logic [31:0] b6, sqp;
    assign b6  = in_w.b5 - 32'd4000;
    assign sqp = b6 * b6;

    // p2: products of b6 and sq with coefficients
    logic        p2_vld_reg;
    logic [31:0] p2_x1a_reg, p2_x2a_reg, p2_x1b_reg, p2_x2b_reg;
    ride_t       p2_r_reg;
    logic [31:0] m1, m2, m3, m4;
    assign m1 = b2 * p1_sq_reg;
    assign m2 = ac2 * p1_b6_reg;
    assign m3 = ac3 * p1_b6_reg;
    assign m4 = b1 * p1_sq_reg;

    // p3: b3, x3
    logic        p3_vld_reg;
    logic [31:0] p3_b3_reg, p3_x3_reg;
    ride_t       p3_r_reg;
    logic [31:0] b3, x3;
    assign b3 = 32'($signed((ac1 << 2) + p2_x1a_reg + p2_x2a_reg + 32'd2) >>> 2);
    assign x3 = 32'($signed(p2_x1b_reg + p2_x2b_reg + 32'd2) >>> 2);

    // p4: b4 product, b7 difference
    logic        p4_vld_reg;
    logic [31:0] p4_b4_reg, p4_d_reg;
    ride_t       p4_r_reg;
    logic [31:0] b4p;
    assign b4p = ac4 * (p3_x3_reg + 32'd32768);

    // p5: b7 product
    logic        p5_vld_reg;
    logic [31:0] p5_b4_reg, p5_b7_reg;
    ride_t       p5_r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
            p4_vld_reg <= 1'b0;
            p5_vld_reg <= 1'b0;
        end
        else
        begin
            p1_vld_reg <= in_vld;
            p2_vld_reg <= p1_vld_reg;
            p3_vld_reg <= p2_vld_reg;
            p4_vld_reg <= p3_vld_reg;
            p5_vld_reg <= p4_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_b6_reg  <= b6;
        p1_sq_reg  <= 32'($signed(sqp) >>> 12);
        p1_r_reg   <= '{t: in_w.t, up: in_w.up, err: in_w.err};
        p2_x1a_reg <= 32'($signed(m1) >>> 11);
        p2_x2a_reg <= 32'($signed(m2) >>> 11);
        p2_x1b_reg <= 32'($signed(m3) >>> 13);
        p2_x2b_reg <= 32'($signed(m4) >>> 16);
        p2_r_reg   <= p1_r_reg;
        p3_b3_reg  <= b3;
        p3_x3_reg  <= x3;
        p3_r_reg   <= p2_r_reg;
        p4_b4_reg  <= b4p >> 15;
        p4_d_reg   <= {16'd0, p3_r_reg.up} - p3_b3_reg;
        p4_r_reg   <= p3_r_reg;
        p5_b4_reg  <= p4_b4_reg;
        p5_b7_reg  <= p4_d_reg * 32'd50000;
        p5_r_reg   <= p4_r_reg;
    end

    // Divide: b7 < 2^31 gives (b7*2)/b4, else (b7/b4)*2.
    logic        big, zero;
    localparam int TW = 32 + 2;
    logic          d_vld;
    logic [31:0]   q;
    logic [TW-1:0] d_tag;
    assign big  = p5_b7_reg[31];
    assign zero = (p5_b4_reg == 32'd0);

    bpc_udiv #(.TAG_W(TW)) u_div (
        .clk(clk), .rst_n(rst_n), .in_vld(p5_vld_reg),
        .num(big ? p5_b7_reg : (p5_b7_reg << 1)),
        .den(zero ? 32'd1 : p5_b4_reg),
        .in_tag({p5_r_reg.t, big, p5_r_reg.err | zero}),
        .out_vld(d_vld), .quot(q), .out_tag(d_tag)
    );

    // c1: p and x1 square
    logic        c1_vld_reg;
    logic [31:0] c1_p_reg, c1_sq_reg, c1_x2_reg;
    logic [32:0] c1_tag_reg;
    logic [31:0] p, ps, x2m;
    assign p   = d_tag[1] ? (q << 1) : q;
    assign ps  = 32'($signed(p) >>> 8);
    assign x2m = (32'd0 - 32'd7357) * p;

    // c2: x1 * 3038
    logic        c2_vld_reg;
    logic [31:0] c2_p_reg, c2_x1_reg, c2_x2_reg;
    logic [32:0] c2_tag_reg;
    logic [31:0] m5;
    assign m5 = c1_sq_reg * 32'd3038;

    logic [31:0] pf;
    assign pf = c2_p_reg + 32'($signed(c2_x1_reg + c2_x2_reg + 32'd3791) >>> 4);

    logic        o_vld_reg;
    logic [31:0] o_p_reg, o_t_reg;
    logic        o_e_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_vld_reg <= 1'b0;
            c2_vld_reg <= 1'b0;
            o_vld_reg  <= 1'b0;
        end
        else
        begin
            c1_vld_reg <= d_vld;
            c2_vld_reg <= c1_vld_reg;
            o_vld_reg  <= c2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c1_p_reg   <= p;
        c1_sq_reg  <= ps * ps;
        c1_x2_reg  <= 32'($signed(x2m) >>> 16);
        c1_tag_reg <= {d_tag[TW-1 -: 32], d_tag[0]};
        c2_p_reg   <= c1_p_reg;
        c2_x1_reg  <= 32'($signed(m5) >>> 16);
        c2_x2_reg  <= c1_x2_reg;
        c2_tag_reg <= c1_tag_reg;
        o_p_reg    <= c2_tag_reg[0] ? 32'd0 : pf;
        o_t_reg    <= c2_tag_reg[0] ? 32'd0 : c2_tag_reg[32:1];
        o_e_reg    <= c2_tag_reg[0];
    end

    assign done          = o_vld_reg;
    assign pressure_pa   = o_p_reg;
    assign temperature_c = o_t_reg;
    assign divide_error  = o_e_reg;
endmodule
`default_nettype wire

// File: rtl/barometric_pressure_compensation.sv
`default_nettype none
`include "barometric_pressure_compensation_defines.svh"
// Barometric pressure compensation, datasheet integer algorithm, oversampling 0.
// Command channel: start high with busy low accepts one word of
//   raw_temperature and raw_pressure. busy stays low: a word may enter every cycle.
// Result channel: done pulses for one cycle with pressure_pa, temperature_c and
//   divide_error. The receiver cannot stall; results appear in input order.
// Config: cfg_we writes cfg_data into register cfg_index (AC1..3, AC4..6, B1/B2,
//   MC/MD). Write only while the pipeline is empty.
// Pipeline: front with 33-stage temperature divider, queue, back with 33-stage
//   pressure divider.
//   Throughput one word per cycle, set by the two bit-per-stage pipelined dividers.
// A zero divisor gives divide_error with zero results.
// Reset (rst_n low, async) clears calibration to zero and flushes the pipeline.
module barometric_pressure_compensation #(
    parameter int QUEUE_DEPTH = bpc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [15:0]               raw_temperature,
    input  wire logic [15:0]               raw_pressure,
    input  wire logic                      cfg_we,
    input  wire logic [bpc_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [bpc_pkg::CFG_W-1:0] cfg_data,
    output logic                           done,
    output logic signed [31:0]             pressure_pa,
    output logic signed [31:0]             temperature_c,
    output logic                           divide_error
);
    logic [47:0] ac123_reg, ac456_reg;
    logic [31:0] b12_reg, mcmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ac123_reg <= '0;
            ac456_reg <= '0;
            b12_reg   <= '0;
            mcmd_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bpc_pkg::REG_AC123: ac123_reg <= cfg_data;
                bpc_pkg::REG_AC456: ac456_reg <= cfg_data;
                bpc_pkg::REG_B12:   b12_reg   <= cfg_data[31:0];
                bpc_pkg::REG_MCMD:  mcmd_reg  <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    logic                 fw_vld, q_ne;
    bpc_pkg::front_word_t fw, qw;

    bpc_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start && !busy),
        .raw_temperature(raw_temperature), .raw_pressure(raw_pressure),
        .cal_b(ac456_reg), .cal_m(mcmd_reg),
        .fw_vld(fw_vld), .fw(fw)
    );

    // Back end never stalls, so the queue drains one word per cycle.
    bpc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n), .wr(fw_vld), .wdata(fw),
        .rd(q_ne), .not_empty(q_ne), .rdata(qw)
    );

    logic [31:0] p_o, t_o;
    bpc_back u_back (
        .clk(clk), .rst_n(rst_n), .in_vld(q_ne), .in_w(qw),
        .cal_a(ac123_reg), .cal_b(ac456_reg), .cal_c(b12_reg),
        .done(done), .pressure_pa(p_o), .temperature_c(t_o),
        .divide_error(divide_error)
    );
    assign pressure_pa   = p_o;
    assign temperature_c = t_o;

    `BPC_ASSERT_IMP(a_err_zero, clk, rst_n, done && divide_error, pressure_pa == 0 && temperature_c == 0, "error word not zero")
    `BPC_ASSERT_NXT(a_start_done, clk, rst_n, 1'b1, !(done && !$past(q_ne, 41)), "done without word")
    `BPC_ASSERT_IMP(a_never_busy, clk, rst_n, start, !busy, "busy raised")
endmodule
`default_nettype wire
